// ----- hw/rtl/bbem_pkg.sv -----
// Shared types and codes for the blocked bit-vector edit-distance matcher.
// No dependencies; the matcher, the word update and the bench refer to it by scoped names.
package bbem_pkg;

    // Input item kinds
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_START   = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MAX_EDITS      = 1'b0;
    localparam logic CFG_PATTERN_LENGTH = 1'b1;

    // Field widths fixed by the stream format
    localparam int SCORE_W = 10;
    localparam int OUT_SCORE_W = 9;
    localparam int EQ_FIELD_W = 64;
    localparam int POS_W = 32;

    // Horizontal carry passed from one block to the next
    typedef struct packed {
        logic pc;
        logic mc;
    } carry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_TAIL,
        ST_SHRINK,
        ST_EMIT
    } fsm_state_t;

endpackage

// ----- hw/rtl/blocked_bitvector_edit_match_unit.sv -----
// Blocked bit-vector approximate matcher with a band of active blocks.
// Text transfer: the active blocks are updated in order, one block update per cycle through
// the difference-word RAM, then a tail check grows the band or, with more than one block,
// shrink steps follow; the result is then loaded and the input is taken again once it is.
// Load and start transfers leave the block idle; a stalled result holds the input.
// Reset (aresetn low, synchronous): k = 0, m = 64, fresh vectors, band at block 0; no table clear.
module blocked_bitvector_edit_match_unit #(
    parameter int WORD_BITS = 64,
    parameter int BLOCKS    = 4,
    parameter int ALPHABET  = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // mode[1:0], symbol[3:2], block_number[5:4], equality_word[69:6],
    // text_position[101:70], zero fill
    input  logic [103:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // end_position[31:0], edit_score[40:32], is_match[41], zero fill
    output logic [47:0]   m_tdata,
    input  logic          cfg_wr_en,
    input  logic          cfg_index,
    input  logic [8:0]    cfg_wdata
);

    localparam int IDX_W    = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W    = IDX_W + 1;
    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int MAXM     = BLOCKS * WORD_BITS;
    localparam int LEN_W    = $clog2(MAXM + 1);
    localparam int CW       = (LEN_W > 9) ? LEN_W : 9;
    localparam int EQ_DEPTH = ALPHABET * BLOCKS;
    localparam int EQ_AW    = (EQ_DEPTH > 1) ? $clog2(EQ_DEPTH) : 1;
    localparam int M0       = (MAXM < 64) ? MAXM : 64;
    localparam int RE0      = (M0 - 1) / WORD_BITS;
    localparam int SW       = bbem_pkg::SCORE_W;

    // Input fields
    logic [1:0]             in_mode;
    logic [1:0]             in_sym;
    logic [1:0]             in_blk;
    logic [WORD_BITS-1:0]   in_eq;
    logic [31:0]            in_pos;
    logic                   in_xfer;

    assign in_mode = s_tdata[1:0];
    assign in_sym  = s_tdata[3:2];
    assign in_blk  = s_tdata[5:4];
    assign in_eq   = s_tdata[6 +: WORD_BITS];
    assign in_pos  = s_tdata[101:70];

    // Control and datapath registers
    bbem_pkg::fsm_state_t   state_reg, state_next;
    logic [7:0]             k_reg;
    logic [8:0]             plen_reg;
    logic [1:0]             sym_reg;
    logic                   sym_ok_reg;
    logic [31:0]            pos_reg;
    logic [IDX_W-1:0]       rd_lim_reg;
    logic [IDX_W-1:0]       ccnt_reg;
    logic [IDX_W-1:0]       rd_reg;
    logic [IDX_W-1:0]       lab_reg;
    bbem_pkg::carry_t       carry_reg;
    logic [SW-1:0]          old_reg;
    logic [BLOCKS-1:0]      fresh_reg;
    logic [SW-1:0]          score_reg [BLOCKS];
    logic                   out_valid_reg;
    logic [31:0]            out_pos_reg;
    logic [8:0]             out_score_reg;
    logic                   out_match_reg;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == bbem_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_match_reg, out_score_reg, out_pos_reg};

    // Derived pattern geometry: effective m, last block, its last pattern bit
    logic [CW-1:0]     plen_ext;
    logic [LEN_W-1:0]  m_eff;
    logic [CW-1:0]     mm1;
    logic [IDX_W-1:0]  re;
    logic [CW-1:0]     s_full;
    logic [BIT_W-1:0]  s_bit;
    logic [10:0]       dim;
    logic [10:0]       diw;
    logic [7:0]        km1;
    logic [IDX_W-1:0]  lab_start;

    always_comb begin
        plen_ext = CW'(plen_reg);
        if (plen_ext == '0) begin
            m_eff = LEN_W'(1);
        end else if (plen_ext > CW'(MAXM)) begin
            m_eff = LEN_W'(MAXM);
        end else begin
            m_eff = LEN_W'(plen_ext);
        end
        mm1 = CW'(m_eff) - CW'(1);
        re = '0;
        for (int b = 1; b < BLOCKS; b++) begin
            if (mm1 >= CW'(b * WORD_BITS)) re = IDX_W'(b);
        end
        s_full = mm1 - CW'(re) * CW'(WORD_BITS);
        s_bit  = BIT_W'(s_full);
        dim = 11'(s_bit) + 11'd1 + 11'(k_reg);
        diw = 11'(WORD_BITS) + 11'(k_reg);
        // Initial band end from k, clamped to the last block
        km1 = k_reg - 8'd1;
        lab_start = '0;
        for (int b = 1; b < BLOCKS; b++) begin
            if (k_reg != 8'd0 && 11'(km1) >= 11'(b * WORD_BITS)) lab_start = IDX_W'(b);
        end
        if (lab_start > re) lab_start = re;
    end

    // RAMs: equality table and {minus, plus} difference words
    logic                  eq_we;
    logic [EQ_AW-1:0]      eq_waddr;
    logic [EQ_AW-1:0]      eq_raddr;
    logic [WORD_BITS-1:0]  eq_rdata;
    logic                  st_we;
    logic [IDX_W-1:0]      st_waddr;
    logic [2*WORD_BITS-1:0] st_wdata;
    logic [IDX_W-1:0]      st_raddr;
    logic [2*WORD_BITS-1:0] st_rdata;
    logic [CNT_W-1:0]      rnext;
    logic [1:0]            rd_sym;

    assign eq_we    = in_xfer && in_mode == bbem_pkg::MODE_LOAD
                      && 32'(in_sym) < 32'(ALPHABET) && 32'(in_blk) < 32'(BLOCKS);
    assign eq_waddr = EQ_AW'(int'(in_sym) * BLOCKS + int'(in_blk));
    assign rnext    = (state_reg == bbem_pkg::ST_IDLE) ? '0 : CNT_W'(ccnt_reg) + CNT_W'(1);
    assign rd_sym   = (state_reg == bbem_pkg::ST_IDLE) ? in_sym : sym_reg;
    assign eq_raddr = EQ_AW'(int'(rd_sym) * BLOCKS + int'(rnext));
    assign st_raddr = IDX_W'(rnext);

    bbem_ram #(.WIDTH(WORD_BITS), .DEPTH(EQ_DEPTH)) u_eq_ram (
        .aclk    (aclk),
        .wr_en   (eq_we),
        .wr_addr (eq_waddr),
        .wr_data (in_eq),
        .rd_addr (eq_raddr),
        .rd_data (eq_rdata)
    );

    bbem_ram #(.WIDTH(2 * WORD_BITS), .DEPTH(BLOCKS)) u_vec_ram (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    // Block update on the word just read; fresh entries read as start vectors
    logic [WORD_BITS-1:0]  upd_eq;
    logic [WORD_BITS-1:0]  upd_p;
    logic [WORD_BITS-1:0]  upd_m;
    logic [WORD_BITS-1:0]  new_p;
    logic [WORD_BITS-1:0]  new_m;
    logic [BIT_W-1:0]      upd_bit;
    bbem_pkg::carry_t      upd_carry;

    assign upd_eq  = sym_ok_reg ? eq_rdata : '0;
    assign upd_p   = fresh_reg[ccnt_reg] ? '1 : st_rdata[WORD_BITS-1:0];
    assign upd_m   = fresh_reg[ccnt_reg] ? '0 : st_rdata[2*WORD_BITS-1:WORD_BITS];
    assign upd_bit = (ccnt_reg == re) ? s_bit : BIT_W'(WORD_BITS - 1);

    bbem_word_update #(.W(WORD_BITS), .BIT_W(BIT_W)) u_upd (
        .eq_word (upd_eq),
        .p_in    (upd_p),
        .m_in    (upd_m),
        .cin     (carry_reg),
        .bit_sel (upd_bit),
        .p_out   (new_p),
        .m_out   (new_m),
        .cout    (upd_carry)
    );

    // Band extension test after the last active block
    logic                  ext_ok;
    logic [SW-1:0]         ext_score;
    logic [IDX_W-1:0]      ext_blk;
    logic [SW-1:0]         new_score;
    logic                  out_load;
    logic [SW-1:0]         fin;

    assign ext_blk  = IDX_W'(rnext);
    assign ext_ok   = (re != '0) && (old_reg == SW'(k_reg)) && (rd_lim_reg < re)
                      && ((sym_ok_reg && eq_rdata[0]) || carry_reg.mc);
    assign ext_score = (ext_blk == re) ? SW'(dim - 11'd1) : SW'(diw - 11'd1);
    assign new_score = score_reg[ccnt_reg] + SW'(upd_carry.pc) - SW'(upd_carry.mc);
    assign fin       = score_reg[rd_reg];
    assign out_load  = (state_reg == bbem_pkg::ST_EMIT) && (!out_valid_reg || m_tready);

    // Difference-word write back
    always_comb begin
        st_we    = 1'b0;
        st_waddr = ccnt_reg;
        st_wdata = {new_m, new_p};
        if (state_reg == bbem_pkg::ST_RUN) begin
            st_we = 1'b1;
        end else if (state_reg == bbem_pkg::ST_TAIL && ext_ok) begin
            st_we    = 1'b1;
            st_waddr = ext_blk;
            st_wdata = {WORD_BITS'(carry_reg.pc),
                        {WORD_BITS{1'b1}} ^ WORD_BITS'(!carry_reg.mc)};
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bbem_pkg::ST_IDLE: begin
                if (in_xfer && in_mode == bbem_pkg::MODE_TEXT) state_next = bbem_pkg::ST_RUN;
            end
            bbem_pkg::ST_RUN: begin
                if (ccnt_reg == rd_lim_reg) state_next = bbem_pkg::ST_TAIL;
            end
            bbem_pkg::ST_TAIL: begin
                if (re == '0 || ext_ok) state_next = bbem_pkg::ST_EMIT;
                else state_next = bbem_pkg::ST_SHRINK;
            end
            bbem_pkg::ST_SHRINK: begin
                if (!(rd_reg < re && 11'(fin) > diw && rd_reg != '0)) begin
                    state_next = bbem_pkg::ST_EMIT;
                end
            end
            bbem_pkg::ST_EMIT: begin
                if (out_load) state_next = bbem_pkg::ST_IDLE;
            end
            default: state_next = bbem_pkg::ST_IDLE;
        endcase
    end

    // State register and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bbem_pkg::ST_IDLE;
            k_reg         <= 8'd0;
            plen_reg      <= 9'd64;
            fresh_reg     <= '1;
            lab_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < BLOCKS; r++) begin
                score_reg[r] <= (r == RE0) ? SW'(M0) : SW'((r + 1) * WORD_BITS);
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    bbem_pkg::CFG_MAX_EDITS:      k_reg    <= cfg_wdata[7:0];
                    bbem_pkg::CFG_PATTERN_LENGTH: plen_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // Start a search: fresh vectors, initial scores and band
            if (in_xfer && in_mode == bbem_pkg::MODE_START) begin
                fresh_reg <= '1;
                lab_reg   <= lab_start;
                for (int r = 0; r < BLOCKS; r++) begin
                    score_reg[r] <= (IDX_W'(r) == re) ? SW'(m_eff) : SW'((r + 1) * WORD_BITS);
                end
            end
            if (state_reg == bbem_pkg::ST_RUN) begin
                fresh_reg[ccnt_reg] <= 1'b0;
                score_reg[ccnt_reg] <= new_score;
            end
            if (state_reg == bbem_pkg::ST_TAIL && ext_ok) begin
                fresh_reg[ext_blk] <= 1'b0;
                score_reg[ext_blk] <= ext_score;
            end
            if (out_load) begin
                lab_reg       <= rd_reg;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-item datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            bbem_pkg::ST_IDLE: begin
                sym_reg    <= in_sym;
                sym_ok_reg <= 32'(in_sym) < 32'(ALPHABET);
                pos_reg    <= in_pos;
                rd_lim_reg <= (lab_reg > re) ? re : lab_reg;
                ccnt_reg   <= '0;
                carry_reg  <= '0;
            end
            bbem_pkg::ST_RUN: begin
                carry_reg <= upd_carry;
                old_reg   <= score_reg[ccnt_reg];
                rd_reg    <= ccnt_reg;
                if (ccnt_reg != rd_lim_reg) ccnt_reg <= ccnt_reg + IDX_W'(1);
            end
            bbem_pkg::ST_TAIL: begin
                if (re == '0) begin
                    rd_reg <= '0;
                end else if (ext_ok) begin
                    rd_reg <= ext_blk;
                end else if (rd_reg == re && 11'(fin) > dim) begin
                    rd_reg <= rd_reg - IDX_W'(1);
                end
            end
            bbem_pkg::ST_SHRINK: begin
                if (rd_reg < re && 11'(fin) > diw && rd_reg != '0) begin
                    rd_reg <= rd_reg - IDX_W'(1);
                end
            end
            default: ;
        endcase
        // Hold the result until the downstream side takes it
        if (out_load) begin
            out_pos_reg   <= pos_reg;
            out_score_reg <= (rd_reg != re) ? 9'd0 : ((fin > SW'(511)) ? 9'd511 : fin[8:0]);
            out_match_reg <= (rd_reg == re) && (fin <= SW'(k_reg));
        end
    end

    // The update loop never runs past the clamped band end
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bbem_pkg::ST_RUN |-> ccnt_reg <= rd_lim_reg)
        else $error("block counter past band end");

    // The tail step always follows the update loop
    a_tail_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bbem_pkg::ST_TAIL |-> $past(state_reg) == bbem_pkg::ST_RUN)
        else $error("tail without update loop");

    // A loaded result is presented on the next cycle
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg)
        else $error("result transfer lost");

endmodule

// ----- hw/rtl/bbem_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the equality table and the difference-word store.
module bbem_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/bbem_word_update.sv -----
// One Myers bit-vector step on a single pattern block word.
// Depends on bbem_pkg for the carry struct.
module bbem_word_update #(
    parameter int W     = 64,
    parameter int BIT_W = 6
) (
    input  logic [W-1:0]      eq_word,
    input  logic [W-1:0]      p_in,
    input  logic [W-1:0]      m_in,
    input  bbem_pkg::carry_t  cin,
    input  logic [BIT_W-1:0]  bit_sel,
    output logic [W-1:0]      p_out,
    output logic [W-1:0]      m_out,
    output bbem_pkg::carry_t  cout
);

    logic [W-1:0] y;
    logic [W-1:0] x;
    logic [W-1:0] u2;
    logic [W-1:0] ph;
    logic [W-1:0] mh;
    logic [W-1:0] yb;

    // Vertical deltas, horizontal deltas, then shifted vertical deltas
    always_comb begin
        y     = eq_word | {{(W-1){1'b0}}, cin.mc};
        x     = (((y & p_in) + p_in) ^ p_in) | y;
        u2    = eq_word | m_in;
        ph    = m_in | ~(x | p_in);
        mh    = p_in & x;
        yb    = {ph[W-2:0], cin.pc};
        p_out = {mh[W-2:0], cin.mc} | ~(u2 | yb);
        m_out = yb & u2;
        cout.pc = ph[bit_sel];
        cout.mc = mh[bit_sel];
    end

endmodule

// ----- dv/blocked_bitvector_edit_match_unit_test.sv -----
// Self-checking bench for the blocked bit-vector edit-distance matcher.
// Drives load, start and text transfers, predicts each score in-bench; uses bbem_pkg.
`timescale 1ns / 100ps

module blocked_bitvector_edit_match_unit_test;

    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic [31:0] pos;
        logic [8:0]  score;
        logic        hit;
    } score_rec_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [103:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [47:0]   m_tdata;
    logic          cfg_wr_en;
    logic          cfg_index;
    logic [8:0]    cfg_wdata;

    // pending input transfers and expected result records
    logic [103:0]  pending_items[$];
    score_rec_t    expected_scores[$];

    // predictor state
    logic [63:0]   eq_tab[16];
    logic [63:0]   plus_w[4];
    logic [63:0]   minus_w[4];
    logic [9:0]    blk_score[4];
    int            band_end;
    int            k_edits;
    int            pat_len;

    int            mismatches;
    int            text_count;
    int            match_count;
    int            result_count;
    int            idle_cycles;
    int            gap_left;
    int            rdy_gap_left;
    int            hold_left;
    int            hold_req;
    int            hold_seen;
    bit            no_idle;
    logic [31:0]   next_pos;
    logic [1:0]    pattern[256];

    blocked_bitvector_edit_match_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic int eff_len();
        int m;
        m = pat_len;
        if (m == 0) m = 1;
        if (m > 256) m = 256;
        return m;
    endfunction

    // restore fresh difference words and the initial band
    function automatic void restart_search();
        int m;
        int re;
        m = eff_len();
        re = (m - 1) / 64;
        for (int r = 0; r < 4; r++) begin
            plus_w[r] = '1;
            minus_w[r] = '0;
            blk_score[r] = (r == re) ? m[9:0] : 10'((r + 1) * 64);
        end
        band_end = (k_edits == 0) ? 0 : (k_edits - 1) / 64;
        if (band_end > re) band_end = re;
    endfunction

    // advance the band over one text symbol and return its score record
    function automatic score_rec_t step_text(logic [1:0] sym, logic [31:0] pos);
        score_rec_t rec;
        int m, re, s, diw, dim, rd, r, old, fin, bpos;
        logic pc, mc;
        logic [63:0] u, p, mw, y, x;
        m = eff_len();
        re = (m - 1) / 64;
        s = m - re * 64 - 1;
        diw = 64 + k_edits;
        dim = s + 1 + k_edits;
        rd = (band_end > re) ? re : band_end;
        pc = 1'b0;
        mc = 1'b0;
        old = 0;
        for (r = 0; r <= rd; r++) begin
            u = eq_tab[sym * 4 + r];
            p = plus_w[r];
            mw = minus_w[r];
            y = u | {63'b0, mc};
            x = (((y & p) + p) ^ p) | y;
            u = u | mw;
            y = p;
            p = mw | ~(x | y);
            mw = y & x;
            y = (p << 1) | {63'b0, pc};
            plus_w[r] = (mw << 1) | {63'b0, mc} | ~(u | y);
            minus_w[r] = y & u;
            old = blk_score[r];
            bpos = (r == re) ? s : 63;
            pc = p[bpos];
            mc = mw[bpos];
            blk_score[r] = blk_score[r] + pc - mc;
        end
        if (re == 0) begin
            rd = 0;
            fin = blk_score[0];
        end else if (old == k_edits && r <= re && (eq_tab[sym * 4 + r][0] | mc)) begin
            // grow the band by one block
            plus_w[r] = {63'h7FFF_FFFF_FFFF_FFFF, mc};
            minus_w[r] = {63'b0, pc};
            fin = ((r == re) ? dim - 1 : diw - 1) & 32'h3FF;
            blk_score[r] = fin[9:0];
            rd = r;
        end else begin
            // shrink the band while scores are out of reach
            fin = blk_score[rd];
            if (rd == re && fin > dim) begin
                rd--;
                fin = blk_score[rd];
            end
            if (rd < re) begin
                while (fin > diw && rd > 0) begin
                    rd--;
                    fin = blk_score[rd];
                end
            end
        end
        band_end = rd;
        rec.pos = pos;
        if (rd == re) begin
            rec.score = (fin > 511) ? 9'd511 : fin[8:0];
            rec.hit = (fin <= k_edits);
        end else begin
            rec.score = '0;
            rec.hit = 1'b0;
        end
        return rec;
    endfunction

    function automatic void predict(logic [103:0] item);
        logic [1:0] mode;
        mode = item[1:0];
        if (mode == bbem_pkg::MODE_LOAD) begin
            eq_tab[item[3:2] * 4 + item[5:4]] = item[69:6];
        end else if (mode == bbem_pkg::MODE_START) begin
            restart_search();
        end else if (mode == bbem_pkg::MODE_TEXT) begin
            expected_scores.push_back(step_text(item[3:2], item[101:70]));
            text_count++;
        end
    endfunction

    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(99);
        if (no_idle || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // driver: offer pending transfers with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) predict(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_tdata <= pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left <= rand_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall the result side and check each result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rdy_gap_left <= 0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_count++;
                if (expected_scores.size() == 0) begin
                    report("unexpected result", 64'(m_tdata), 64'h0);
                end else begin
                    score_rec_t want;
                    want = expected_scores.pop_front();
                    if (m_tdata[31:0] !== want.pos)
                        report("end_position", 64'(m_tdata[31:0]), 64'(want.pos));
                    if (m_tdata[40:32] !== want.score)
                        report("edit_score", 64'(m_tdata[40:32]), 64'(want.score));
                    if (m_tdata[41] !== want.hit)
                        report("is_match", 64'(m_tdata[41]), 64'(want.hit));
                    if (want.hit) match_count++;
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= 400;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (rdy_gap_left > 0) begin
                rdy_gap_left <= rdy_gap_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rdy_gap_left <= ($urandom_range(3) == 0) ? rand_gap() : 0;
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(logic [1:0] mode, logic [1:0] sym, logic [1:0] blk,
                             logic [63:0] eq, logic [31:0] pos);
        pending_items.push_back({2'b00, pos, eq, blk, sym, mode});
    endtask

    task automatic push_text(logic [1:0] sym);
        push_item(bbem_pkg::MODE_TEXT, sym, 2'($urandom), {$urandom, $urandom}, next_pos);
        next_pos++;
    endtask

    // hold until the block has drained, then let its pipeline settle
    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_scores.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == bbem_pkg::CFG_MAX_EDITS) k_edits = val[7:0];
        else pat_len = val;
        @(posedge aclk);
    endtask

    // random pattern, loaded as all sixteen equality words
    task automatic load_pattern();
        logic [63:0] w;
        for (int i = 0; i < 256; i++) pattern[i] = 2'($urandom);
        for (int sy = 0; sy < 4; sy++) begin
            for (int b = 0; b < 4; b++) begin
                for (int i = 0; i < 64; i++) w[i] = (pattern[b * 64 + i] == sy);
                push_item(bbem_pkg::MODE_LOAD, sy[1:0], b[1:0], w, $urandom);
            end
        end
    endtask

    // text partly carrying edited copies of the pattern, short patterns only
    task automatic push_phase_text(int n);
        int m, pick, sent;
        m = eff_len();
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                if (m <= 3 * n) begin
                    for (int i = 0; i < m; i++) begin
                        pick = $urandom_range(99);
                        if (pick < 88) begin
                            push_text(pattern[i]);
                        end else if (pick < 94) begin
                            push_text(2'($urandom));
                            push_text(pattern[i]);
                            sent++;
                        end else if (pick < 97) begin
                            push_text(2'($urandom));
                        end
                        sent++;
                    end
                end else begin
                    push_text(2'($urandom));
                    sent++;
                end
            end else if (pick < 38) begin
                push_item(bbem_pkg::MODE_IGNORED, 2'($urandom), 2'($urandom),
                          {$urandom, $urandom}, $urandom);
            end else if (pick < 40) begin
                push_item(bbem_pkg::MODE_START, 2'($urandom), 2'($urandom),
                          {$urandom, $urandom}, $urandom);
            end else begin
                push_text(2'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        int ks[10] = '{0, 3, 2, 5, 10, 255, 0, 7, 40, 64};
        int ms[10] = '{1, 20, 64, 100, 200, 256, 0, 300, 130, 511};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        text_count = 0;
        match_count = 0;
        result_count = 0;
        idle_cycles = 0;
        hold_req = 0;
        hold_seen = 0;
        no_idle = 1'b0;
        next_pos = 0;
        k_edits = 0;
        pat_len = 64;
        for (int i = 0; i < 16; i++) eq_tab[i] = '0;
        restart_search();
        band_end = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extreme equality words, extreme positions, ignored mode
        for (int sy = 0; sy < 4; sy++)
            for (int b = 0; b < 4; b++)
                push_item(bbem_pkg::MODE_LOAD, sy[1:0], b[1:0],
                          (sy == 0) ? '1 : (sy == 1) ? '0 : {$urandom, $urandom}, '1);
        push_item(bbem_pkg::MODE_TEXT, 2'd0, 2'd3, '1, 32'h0);
        push_item(bbem_pkg::MODE_TEXT, 2'd1, 2'd0, '0, 32'hFFFF_FFFF);
        push_item(bbem_pkg::MODE_IGNORED, 2'd3, 2'd3, '1, '1);
        push_item(bbem_pkg::MODE_START, 2'd0, 2'd0, '0, '0);
        push_item(bbem_pkg::MODE_TEXT, 2'd2, 2'd1, '0, 32'h5555_5555);
        push_item(bbem_pkg::MODE_TEXT, 2'd3, 2'd2, '1, 32'hAAAA_AAAA);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(bbem_pkg::CFG_MAX_EDITS, ks[ph][8:0]);
            write_reg(bbem_pkg::CFG_PATTERN_LENGTH, ms[ph][8:0]);
            no_idle = (ph % 4 == 3);
            load_pattern();
            // one phase keeps the old search to see a length change mid-search
            if (ph != 8)
                push_item(bbem_pkg::MODE_START, 2'($urandom), 2'($urandom),
                          {$urandom, $urandom}, '0);
            if (ph == 2) hold_req++;
            push_phase_text(30);
            if (ph == 4) drain();
            push_phase_text(20);
            drain();
        end

        drain();
        $display("covered %0d text symbols and %0d results (%0d matches) over ten settings",
                 text_count, result_count, match_count);
        $display("settings ran k from 0 to 255 and m from 0 to 511, with stalls on both sides");
        if (mismatches == 0 && expected_scores.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
